>>> rtl/md5_pkg.sv
// Package with MD5 types, constants and round tables.
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumBlockWords = 16;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned LenW = 61;

  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hEFCDAB89;
  localparam logic [WordW-1:0] InitC = 32'h98BADCFE;
  localparam logic [WordW-1:0] InitD = 32'h10325476;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [3:0] word_idx_t;
  typedef logic [5:0] round_idx_t;

  // Write source selection for the block buffer.
  typedef enum logic [2:0] {
    WrNone  = 3'd0,
    WrByte  = 3'd1,
    WrPad   = 3'd2,
    WrZero  = 3'd3,
    WrLenLo = 3'd4,
    WrLenHi = 3'd5
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take_byte;   // merge the input byte into the buffer
    wr_sel_e   wr_sel;      // extra buffer write
    word_idx_t wr_idx;      // word index for extra write
    logic      start_comp;  // load working registers from the chain value
    logic      round_en;    // perform one round
    round_idx_t round;      // current round number
    logic      fold;        // add working registers into the chain value
    logic      clr_msg;     // reset chain value and counters
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;       // bytes in the current block
  } dp_sts_t;

  function automatic logic [WordW-1:0] step_const(input round_idx_t i);
    logic [WordW-1:0] k;
    unique case (i)
      6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;  6'd2: k = 32'h242070DB;
      6'd3: k = 32'hC1BDCEEE;  6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
      6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;  6'd8: k = 32'h698098D8;
      6'd9: k = 32'h8B44F7AF;  6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
      6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
      6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
      6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
      6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
      6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
      6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
      6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
      default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input round_idx_t i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'hA: s = 5'd16; 4'hB: s = 5'd23;
      4'hC: s = 5'd6;  4'hD: s = 5'd10; 4'hE: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by round i.
  function automatic word_idx_t msg_index(input round_idx_t i);
    logic [7:0] g;
    unique case (i[5:4])
      2'd0: g = {2'b00, i};
      2'd1: g = ({2'b00, i} << 2) + {2'b00, i} + 8'd1;
      2'd2: g = ({2'b00, i} << 1) + {2'b00, i} + 8'd5;
      default: g = ({2'b00, i} << 3) - {2'b00, i};
    endcase
    return g[3:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/md5_stream_if.sv
// Valid/ready stream interfaces for message bytes and digest words.
`timescale 1ns / 1ps
`default_nettype none
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

>>> rtl/md5_datapath.sv
// MD5 datapath: block buffer, counters, round unit and chaining value.
`timescale 1ns / 1ps
`default_nettype none
module md5_datapath (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  md5_pkg::dp_cmd_t  cmd_i,
  input  wire  logic [7:0]        byte_i,
  input  wire  logic [1:0]        rd_idx_i,
  output md5_pkg::dp_sts_t        sts_o,
  output logic [31:0]             chain_word_o
);

  logic [31:0] blk_q [md5_pkg::NumBlockWords];
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] wa_q, wb_q, wc_q, wd_q;
  logic [5:0]  fill_q;
  logic [md5_pkg::LenW-1:0] len_q;
  logic [63:0] bits;

  logic [31:0] f_val, sum, rot;
  logic [4:0]  sh;
  logic [31:0] cur_word, merged;
  logic [1:0]  lane;

  assign bits = {len_q, 3'b000};
  assign lane = fill_q[1:0];
  assign cur_word = blk_q[fill_q[5:2]];

  always_comb begin
    merged = cur_word;
    unique case (lane)
      2'd0: merged = {24'd0, byte_i};
      2'd1: merged = {cur_word[31:16], byte_i, cur_word[7:0]};
      2'd2: merged = {cur_word[31:24], byte_i, cur_word[15:0]};
      default: merged = {byte_i, cur_word[23:0]};
    endcase
  end

  always_comb begin
    unique case (cmd_i.round[5:4])
      2'd0: f_val = wd_q ^ (wb_q & (wc_q ^ wd_q));
      2'd1: f_val = wc_q ^ (wd_q & (wb_q ^ wc_q));
      2'd2: f_val = wb_q ^ wc_q ^ wd_q;
      default: f_val = wc_q ^ (wb_q | ~wd_q);
    endcase
    sum = wa_q + f_val + blk_q[md5_pkg::msg_index(cmd_i.round)]
        + md5_pkg::step_const(cmd_i.round);
    sh  = md5_pkg::rot_amount(cmd_i.round);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  // Pad word: keep the bytes below the fill point and place 0x80 there.
  logic [31:0] pad_word;
  always_comb begin
    unique case (lane)
      2'd0: pad_word = {24'd0, md5_pkg::PadByte};
      2'd1: pad_word = {16'd0, md5_pkg::PadByte, cur_word[7:0]};
      2'd2: pad_word = {8'd0, md5_pkg::PadByte, cur_word[15:0]};
      default: pad_word = {md5_pkg::PadByte, cur_word[23:0]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      blk_q[fill_q[5:2]] <= merged;
    end
    unique case (cmd_i.wr_sel)
      md5_pkg::WrPad:   blk_q[cmd_i.wr_idx] <= pad_word;
      md5_pkg::WrZero:  blk_q[cmd_i.wr_idx] <= '0;
      md5_pkg::WrLenLo: blk_q[cmd_i.wr_idx] <= bits[31:0];
      md5_pkg::WrLenHi: blk_q[cmd_i.wr_idx] <= bits[63:32];
      default: ;
    endcase
    if (cmd_i.start_comp) begin
      wa_q <= chain_q[0];
      wb_q <= chain_q[1];
      wc_q <= chain_q[2];
      wd_q <= chain_q[3];
    end else if (cmd_i.round_en) begin
      wa_q <= wd_q;
      wd_q <= wc_q;
      wc_q <= wb_q;
      wb_q <= wb_q + rot;
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (cmd_i.clr_msg) begin
      chain_d[0] = md5_pkg::InitA;
      chain_d[1] = md5_pkg::InitB;
      chain_d[2] = md5_pkg::InitC;
      chain_d[3] = md5_pkg::InitD;
    end else if (cmd_i.fold) begin
      chain_d[0] = chain_q[0] + wa_q;
      chain_d[1] = chain_q[1] + wb_q;
      chain_d[2] = chain_q[2] + wc_q;
      chain_d[3] = chain_q[3] + wd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= md5_pkg::InitA;
      chain_q[1] <= md5_pkg::InitB;
      chain_q[2] <= md5_pkg::InitC;
      chain_q[3] <= md5_pkg::InitD;
      fill_q <= '0;
      len_q  <= '0;
    end else begin
      chain_q <= chain_d;
      if (cmd_i.clr_msg) begin
        fill_q <= '0;
        len_q  <= '0;
      end else if (cmd_i.take_byte) begin
        fill_q <= fill_q + 6'd1;
        len_q  <= len_q + 61'd1;
      end
    end
  end

  assign sts_o.fill = fill_q;
  assign chain_word_o = chain_q[rd_idx_i];

endmodule
`default_nettype wire

>>> rtl/md5_ctrl.sv
// MD5 controller: sequences byte intake, padding, rounds and digest output.
`timescale 1ns / 1ps
`default_nettype none
module md5_ctrl (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  md5_in_if.sink                 in_if,
  output logic                   out_valid_o,
  input  wire  logic             out_ready_i,
  output logic [1:0]             out_idx_o,
  input  wire  md5_pkg::dp_sts_t sts_i,
  output md5_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRound = 7'b0000010,
    StFold  = 7'b0000100,
    StPad   = 7'b0001000,
    StZero  = 7'b0010000,
    StLen   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [3:0] zidx_q, zidx_d;
  logic [1:0] oidx_q, oidx_d;
  logic       closing_q, closing_d;  // message close in progress
  logic       final_q, final_d;      // the running compression is the last one
  logic       pend_q, pend_d;        // close still to do after a full block
  logic       spill_q, spill_d;      // padded block already compressed ahead of the length
  logic       acc;

  assign in_if.ready = (state_q == StIdle);
  assign acc = in_if.valid && in_if.ready;
  assign out_valid_o = (state_q == StOut);
  assign out_idx_o = oidx_q;

  always_comb begin
    state_d = state_q;
    rnd_d = rnd_q;
    zidx_d = zidx_q;
    oidx_d = oidx_q;
    closing_d = closing_q;
    final_d = final_q;
    pend_d = pend_q;
    spill_d = spill_q;
    cmd_o = '0;
    cmd_o.wr_sel = md5_pkg::WrNone;
    cmd_o.round = rnd_q;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          cmd_o.take_byte = in_if.has_byte;
          if (in_if.has_byte && sts_i.fill == 6'd63) begin
            cmd_o.start_comp = 1'b1;
            rnd_d = '0;
            closing_d = 1'b0;
            final_d = 1'b0;
            pend_d = in_if.end_of_message;
            state_d = StRound;
          end else if (in_if.end_of_message) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        cmd_o.wr_sel = md5_pkg::WrPad;
        cmd_o.wr_idx = sts_i.fill[5:2];
        zidx_d = sts_i.fill[5:2] + 4'd1;
        closing_d = 1'b1;
        state_d = (sts_i.fill[5:2] == 4'd15) ? StLen : StZero;
      end
      StZero: begin
        cmd_o.wr_sel = md5_pkg::WrZero;
        cmd_o.wr_idx = zidx_q;
        zidx_d = zidx_q + 4'd1;
        if (zidx_q == 4'd15) state_d = StLen;
      end
      StLen: begin
        if (sts_i.fill >= 6'd56 && closing_q && !final_q && !spill_q) begin
          // Padding spills over: compress this block first.
          cmd_o.start_comp = 1'b1;
          rnd_d = '0;
          zidx_d = 4'd0;
          spill_d = 1'b1;
          state_d = StRound;
        end else begin
          cmd_o.wr_sel = md5_pkg::WrLenLo;
          cmd_o.wr_idx = 4'd14;
          final_d = 1'b1;
          state_d = StRound;
          rnd_d = '0;
          cmd_o.start_comp = 1'b1;
        end
      end
      StRound: begin
        if (final_q && rnd_q == 6'd0 && zidx_q != 4'd15) begin
          // Second length word lands before round 15 reads it.
          cmd_o.wr_sel = md5_pkg::WrLenHi;
          cmd_o.wr_idx = 4'd15;
          zidx_d = 4'd15;
        end
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        if (final_q) begin
          oidx_d = '0;
          state_d = StOut;
        end else if (closing_q) begin
          // Second closing block: all zero but the length.
          zidx_d = 4'd0;
          state_d = StZero;
        end else if (pend_q) begin
          pend_d = 1'b0;
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            cmd_o.clr_msg = 1'b1;
            final_d = 1'b0;
            closing_d = 1'b0;
            spill_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q <= '0;
      zidx_q <= '0;
      oidx_q <= '0;
      closing_q <= 1'b0;
      final_q <= 1'b0;
      pend_q <= 1'b0;
      spill_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q <= rnd_d;
      zidx_q <= zidx_d;
      oidx_q <= oidx_d;
      closing_q <= closing_d;
      final_q <= final_d;
      pend_q <= pend_d;
      spill_q <= spill_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_valid_o) else $error("ready while emitting digest");
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q != 6'd63) |=> state_q == StRound)
    else $error("round sequence broken");
  a_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && oidx_q == 2'd3) |=> state_q == StIdle)
    else $error("no return to idle after last word");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
`endif

endmodule
`default_nettype wire

>>> rtl/md5_message_digest_top.sv
// Top level of the MD5 message digest block.
//
// The block takes requests on in_if, one message byte per request. A request
// with has_byte low carries no byte; end_of_message closes the message. Each
// 64th byte starts a compression of 64 rounds, one round per cycle, in a
// single shared round unit; input is not taken while it runs.
// Closing a message writes the pad byte and zero fill one word per cycle,
// then runs one or two compressions (two when 56 or more bytes sit in the
// last block) and then presents the first digest
// word. The four digest words then go out on out_if, word A first, last_word
// set on the fourth. A stalled receiver holds the current word; no new
// request is taken until all four are gone.
// After the last word the chaining value and the counters return to the MD5
// initial state and the next message may start.
// Reset is asynchronous and active low. It loads the initial chaining value
// and clears the byte counters; the block buffer needs no reset because every
// word is written before a round reads it.
`timescale 1ns / 1ps
`default_nettype none
module md5_message_digest_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  md5_in_if.sink    in_if,
  md5_out_if.source out_if
);

  md5_pkg::dp_cmd_t cmd;
  md5_pkg::dp_sts_t sts;
  logic [1:0]       out_idx;
  logic [31:0]      chain_word;
  logic             out_valid;

  md5_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_valid_o(out_valid),
    .out_ready_i(out_if.ready),
    .out_idx_o  (out_idx),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  md5_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .byte_i      (in_if.data_byte),
    .rd_idx_i    (out_idx),
    .sts_o       (sts),
    .chain_word_o(chain_word)
  );

  assign out_if.valid       = out_valid;
  assign out_if.digest_word = chain_word;
  assign out_if.word_index  = out_idx;
  assign out_if.last_word   = (out_idx == 2'd3);

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the MD5 message digest block.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_res_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 400;

  logic clk_i;
  logic rst_ni;

  md5_in_if  in_if ();
  md5_out_if out_if ();

  md5_message_digest_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Predictor state.
  logic [31:0] chain_q [4];
  logic [31:0] block_q [16];
  logic [5:0]  fill_q;
  logic [60:0] length_q;

  byte_req_t   pending_reqs [$];
  digest_res_t expected_words [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned err_count;
  int unsigned quiet_cycles;

  // The per-round constant, shift and message index are written out here
  // from the MD5 definition rather than taken from the package functions.
  function automatic logic [31:0] round_const(int i);
    logic [31:0] k [64] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE, 32'hF57C0FAF, 32'h4787C62A,
      32'hA8304613, 32'hFD469501, 32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821, 32'hF61E2562, 32'hC040B340,
      32'h265E5A51, 32'hE9B6C7AA, 32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED, 32'hA9E3E905, 32'hFCEFA3F8,
      32'h676F02D9, 32'h8D2A4C8A, 32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70, 32'h289B7EC6, 32'hEAA127FA,
      32'hD4EF3085, 32'h04881D05, 32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039, 32'h655B59C3, 32'h8F0CCC92,
      32'hFFEFF47D, 32'h85845DD1, 32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};
    return k[i];
  endfunction

  function automatic int round_shift(int i);
    int s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return s[(i / 16) * 4 + (i % 4)];
  endfunction

  task automatic run_compression();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = 5 * i + 1; end
        2: begin f = b ^ c ^ d; g = 3 * i + 5; end
        default: begin f = c ^ (b | ~d); g = 7 * i; end
      endcase
      t = a + f + block_q[g % 16] + round_const(i);
      a = d; d = c; c = b;
      b = b + ((t << round_shift(i)) | (t >> (32 - round_shift(i))));
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
  endtask

  task automatic reset_chain();
    chain_q = '{md5_pkg::InitA, md5_pkg::InitB, md5_pkg::InitC, md5_pkg::InitD};
    fill_q = '0;
    length_q = '0;
  endtask

  // Works out the digest words that one accepted request causes.
  task automatic predict_digest(byte_req_t req);
    int w, sh;
    logic [63:0] bits;
    if (req.has_byte) begin
      w = fill_q / 4;
      sh = 8 * (fill_q % 4);
      if (sh == 0) block_q[w] = {24'h0, req.data_byte};
      else block_q[w] |= {24'h0, req.data_byte} << sh;
      length_q += 1;
      fill_q += 1;
      if (fill_q == 0) run_compression();
    end
    if (req.end_of_message) begin
      w = fill_q / 4;
      sh = 8 * (fill_q % 4);
      bits = {length_q, 3'b000};
      if (sh == 0) block_q[w] = 32'h80;
      else block_q[w] = (block_q[w] & ((32'h1 << sh) - 1)) | (32'h80 << sh);
      for (int i = w + 1; i < 16; i++) block_q[i] = '0;
      if (fill_q >= 56) begin
        run_compression();
        for (int i = 0; i < 16; i++) block_q[i] = '0;
      end
      block_q[14] = bits[31:0];
      block_q[15] = bits[63:32];
      run_compression();
      for (int i = 0; i < 4; i++) begin
        expected_words.push_back('{chain_q[i], 2'(i), i == 3});
      end
      reset_chain();
    end
  endtask

  function automatic byte_req_t rand_byte(bit eom);
    return '{8'($urandom_range(0, 255)), 1'b1, eom};
  endfunction

  // Queues a message of n random bytes; the closing item may carry the
  // last byte or be an empty end.
  task automatic queue_message(int n, bit end_with_byte);
    for (int i = 0; i < n; i++) begin
      pending_reqs.push_back(rand_byte(end_with_byte && i == n - 1));
      if ($urandom_range(0, 15) == 0) pending_reqs.push_back('{8'($urandom), 1'b0, 1'b0});
    end
    if (!end_with_byte || n == 0) pending_reqs.push_back('{8'($urandom), 1'b0, 1'b1});
  endtask

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Driver: presents the next pending request, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
      in_if.has_byte <= 1'b0;
      in_if.end_of_message <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        byte_req_t req;
        req = pending_reqs.pop_front();
        in_if.valid <= 1'b1;
        in_if.data_byte <= req.data_byte;
        in_if.has_byte <= req.has_byte;
        in_if.end_of_message <= req.end_of_message;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on accepted requests and checks accepted digest words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_if.ready <= $urandom_range(0, 99) >= recv_idle_pct;
      if (in_if.valid && in_if.ready) begin
        predict_digest('{in_if.data_byte, in_if.has_byte, in_if.end_of_message});
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected digest word %h", out_if.digest_word);
          err_count++;
        end else begin
          digest_res_t exp_w;
          exp_w = expected_words.pop_front();
          if (out_if.digest_word !== exp_w.digest_word) begin
            $error("digest_word: expected %h, got %h", exp_w.digest_word, out_if.digest_word);
            err_count++;
          end
          if (out_if.word_index !== exp_w.word_index) begin
            $error("word_index: expected %0d, got %0d", exp_w.word_index, out_if.word_index);
            err_count++;
          end
          if (out_if.last_word !== exp_w.last_word) begin
            $error("last_word: expected %0d, got %0d", exp_w.last_word, out_if.last_word);
            err_count++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on cycles in which nothing is accepted.
  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int n;
    err_count = 0;
    send_idle_pct = 24;
    recv_idle_pct = 67;
    reset_chain();
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty message, an idle item with a set data byte,
    // an ignored byte on the empty end, the byte-with-end case, field
    // extremes, and fill levels around the one/two compression boundary.
    pending_reqs.push_back('{8'hFF, 1'b0, 1'b0});
    pending_reqs.push_back('{8'hA5, 1'b0, 1'b1});
    pending_reqs.push_back('{8'h00, 1'b1, 1'b1});
    pending_reqs.push_back('{8'hFF, 1'b1, 1'b0});
    pending_reqs.push_back('{8'h5A, 1'b0, 1'b1});
    pending_reqs.push_back('{8'hFF, 1'b1, 1'b1});
    // The remaining fill-level and multi-block cases are random content
    // messages of chosen length.
    queue_message(56, 1'b1);
    queue_message(63, 1'b0);
    queue_message(64, 1'b1);

    // Random part: short messages, split over three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      n = 0;
      while (n < 6) begin
        int len;
        len = $urandom_range(0, 8);
        queue_message(len, $urandom_range(0, 1));
        n += len + 1;
      end
      wait (pending_reqs.size() == 0 && expected_words.size() == 0);
      if (phase == 0) begin
        send_idle_pct = 67;
        recv_idle_pct = 24;
      end else if (phase == 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    wait (pending_reqs.size() == 0 && !in_if.valid && expected_words.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
